// ===== hdl/qsu_pkg.sv =====
`default_nettype none

package qsu_pkg;

    // offsets from the opening quote, saturating
    localparam int unsigned OFFSET_BITS = 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // scan modes
    typedef enum logic [2:0] {
        MODE_OPEN     = 3'd0,
        MODE_DQ       = 3'd1,
        MODE_ESC      = 3'd2,
        MODE_SQ       = 3'd3,
        MODE_SQ_QUOTE = 3'd4,
        MODE_AFTER    = 3'd5,
        MODE_SKIP     = 3'd6
    } t_scan_mode;

    // error kinds as reported on status
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NO_OPEN         = 3'd1,
        ST_TRAILING        = 3'd2,
        ST_INCOMPLETE_ESC  = 3'd3,
        ST_UNSUPPORTED_ESC = 3'd4,
        ST_UNTERMINATED    = 3'd5
    } t_status;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_esc;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    // character after a backslash to the byte it stands for
    function automatic t_esc esc_decode(input logic [7:0] c);
        t_esc e;
        e.ok = 1'b1;
        case (c)
            CH_LOW_B:  e.value = CH_BS;
            CH_LOW_T:  e.value = CH_TAB;
            CH_LOW_N:  e.value = CH_LF;
            CH_LOW_F:  e.value = CH_FF;
            CH_LOW_R:  e.value = CH_CR;
            CH_DQUOTE: e.value = CH_DQUOTE;
            CH_SLASH:  e.value = CH_SLASH;
            CH_BSLASH: e.value = CH_BSLASH;
            default: begin
                e.ok    = 1'b0;
                e.value = 8'h00;
            end
        endcase
        return e;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] offset_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qsu_in_if.sv =====
`default_nettype none

interface qsu_in_if #(
    parameter int unsigned LINE_BITS   = 20,
    parameter int unsigned COLUMN_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             text_byte;
    logic                   last_byte;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;

    modport source (output valid, text_byte, last_byte, start_line, start_column,
                    input ready);
    modport sink (input valid, text_byte, last_byte, start_line, start_column,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/qsu_out_if.sv =====
`default_nettype none

interface qsu_out_if #(
    parameter int unsigned LINE_BITS   = 20,
    parameter int unsigned COLUMN_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             out_byte;
    logic                   out_valid;
    logic                   done_res;
    logic [2:0]             status;
    logic [LINE_BITS-1:0]   error_line;
    logic [COLUMN_BITS-1:0] error_column;

    modport source (output valid, out_byte, out_valid, done_res, status, error_line,
                    error_column, input ready);
    modport sink (input valid, out_byte, out_valid, done_res, status, error_line,
                  error_column, output ready);
endinterface

`default_nettype wire

// ===== hdl/quoted_string_unescaper_core.sv =====
// channel  | dir | modport | payload
// ---------+-----+---------+-------------------------------------------------------
// i_in     | in  | sink    | text_byte, last_byte, start_line, start_column
// o_out    | out | source  | out_byte, out_valid, done_res, status, error_line,
//          |     |         | error_column
//
// one byte per clock sustained while o_out is ready; each transaction passes an input
// register and then a result register before it shows on o_out
// the scan state updates once per byte as it moves from input to result register
// reset is synchronous and active low; the scanner then expects an opening quote
// a stalled result holds in its register; the input register still accepts one
// transaction and moves it on the cycle the result is taken
`default_nettype none

module quoted_string_unescaper_core
    import qsu_pkg::*;
#(
    parameter int unsigned COLUMN_BITS = 16,
    parameter int unsigned LINE_BITS   = 20
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    qsu_in_if.sink   i_in,
    qsu_out_if.source o_out
);

    localparam int unsigned SUM_W =
        ((COLUMN_BITS > OFFSET_BITS) ? COLUMN_BITS : OFFSET_BITS) + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    // input register
    logic                   r_s1_valid;
    logic [7:0]             r_s1_byte;
    logic                   r_s1_last;
    logic [LINE_BITS-1:0]   r_s1_line;
    logic [COLUMN_BITS-1:0] r_s1_col;

    // scan state
    t_scan_mode             r_mode,  n_mode;
    logic [OFFSET_BITS-1:0] r_off,   n_off;
    logic [LINE_BITS-1:0]   r_sline, n_sline;
    logic [COLUMN_BITS-1:0] r_scol,  n_scol;
    t_status                r_ekind, n_ekind;
    logic [OFFSET_BITS-1:0] r_eoff,  n_eoff;

    // result register
    logic                   r_res_valid;
    logic [7:0]             r_res_byte,  n_res_byte;
    logic                   r_res_bvalid, n_res_bvalid;
    logic                   r_res_done;
    t_status                r_res_status;
    logic [LINE_BITS-1:0]   r_res_line,  n_res_line;
    logic [COLUMN_BITS-1:0] r_res_col,   n_res_col;

    logic                   s1_adv;
    logic [OFFSET_BITS-1:0] off_cur;
    logic [SUM_W-1:0]       col_sum;
    t_esc                   esc;

    // the input register moves on when the result register is free or being taken
    assign s1_adv     = r_s1_valid && (!r_res_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.text_byte;
            r_s1_last <= i_in.last_byte;
            r_s1_line <= i_in.start_line;
            r_s1_col  <= i_in.start_column;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OPEN;
            r_off   <= '0;
            r_sline <= '0;
            r_scol  <= '0;
            r_ekind <= ST_OK;
            r_eoff  <= '0;
        end else if (s1_adv) begin
            r_mode  <= n_mode;
            r_off   <= n_off;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_ekind <= n_ekind;
            r_eoff  <= n_eoff;
        end
    end

    assign esc = esc_decode(r_s1_byte);
    // a new scalar counts from its opening quote at zero
    assign off_cur = (r_mode == MODE_OPEN) ? '0 : r_off;

    // next state and decoded byte for the byte in the input register
    always_comb begin
        n_mode       = r_mode;
        n_sline      = r_sline;
        n_scol       = r_scol;
        n_ekind      = r_ekind;
        n_eoff       = r_eoff;
        n_res_bvalid = 1'b0;
        n_res_byte   = 8'h00;

        case (r_mode)
            MODE_OPEN: begin
                n_ekind = ST_OK;
                n_eoff  = '0;
                n_sline = r_s1_line;
                n_scol  = r_s1_col;
                if (r_s1_byte == CH_DQUOTE) begin
                    n_mode = MODE_DQ;
                end else if (r_s1_byte == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                end else begin
                    n_mode  = MODE_SKIP;
                    n_ekind = ST_NO_OPEN;
                end
                // a lone quote never closes
                if (r_s1_last && n_mode != MODE_SKIP) begin
                    n_mode  = MODE_SKIP;
                    n_ekind = ST_UNTERMINATED;
                end
            end
            MODE_DQ: begin
                if (r_s1_byte == CH_DQUOTE) begin
                    n_mode = MODE_AFTER;
                    n_eoff = offset_inc(r_off);
                end else if (r_s1_byte == CH_BSLASH) begin
                    if (r_s1_last) begin
                        n_mode  = MODE_SKIP;
                        n_ekind = ST_INCOMPLETE_ESC;
                        n_eoff  = r_off;
                    end else begin
                        n_mode = MODE_ESC;
                    end
                end else begin
                    n_res_bvalid = 1'b1;
                    n_res_byte   = r_s1_byte;
                    if (r_s1_last) begin
                        n_mode  = MODE_SKIP;
                        n_ekind = ST_UNTERMINATED;
                        n_eoff  = '0;
                    end
                end
            end
            MODE_ESC: begin
                if (!esc.ok) begin
                    // report at the backslash
                    n_mode  = MODE_SKIP;
                    n_ekind = ST_UNSUPPORTED_ESC;
                    n_eoff  = (r_off == '0) ? '0 : r_off - 1'b1;
                end else begin
                    n_res_bvalid = 1'b1;
                    n_res_byte   = esc.value;
                    n_mode       = MODE_DQ;
                    if (r_s1_last) begin
                        n_mode  = MODE_SKIP;
                        n_ekind = ST_UNTERMINATED;
                        n_eoff  = '0;
                    end
                end
            end
            MODE_SQ: begin
                if (r_s1_byte == CH_SQUOTE) begin
                    n_mode = MODE_SQ_QUOTE;
                end else begin
                    n_res_bvalid = 1'b1;
                    n_res_byte   = r_s1_byte;
                    if (r_s1_last) begin
                        n_mode  = MODE_SKIP;
                        n_ekind = ST_UNTERMINATED;
                        n_eoff  = '0;
                    end
                end
            end
            MODE_SQ_QUOTE: begin
                // doubled quote gives one quote, one byte late
                if (r_s1_byte == CH_SQUOTE) begin
                    n_res_bvalid = 1'b1;
                    n_res_byte   = CH_SQUOTE;
                    n_mode       = MODE_SQ;
                    if (r_s1_last) begin
                        n_mode  = MODE_SKIP;
                        n_ekind = ST_UNTERMINATED;
                        n_eoff  = '0;
                    end
                end else if (is_space(r_s1_byte)) begin
                    n_mode = MODE_AFTER;
                    n_eoff = r_off;
                end else begin
                    n_mode  = MODE_SKIP;
                    n_ekind = ST_TRAILING;
                    n_eoff  = r_off;
                end
            end
            MODE_AFTER: begin
                if (!is_space(r_s1_byte)) begin
                    n_mode  = MODE_SKIP;
                    n_ekind = ST_TRAILING;
                end
            end
            default: begin
                // skip after an error, and any unused code
                n_mode = MODE_SKIP;
            end
        endcase

        if (r_s1_last) begin
            n_mode = MODE_OPEN;
        end
    end

    assign n_off = offset_inc(off_cur);

    // error position: saved column plus offset, saturating
    assign col_sum = SUM_W'(n_scol) + SUM_W'(n_eoff);

    always_comb begin
        if (n_ekind == ST_OK) begin
            n_res_line = '0;
            n_res_col  = '0;
        end else begin
            n_res_line = n_sline;
            n_res_col  = (col_sum > SUM_W'(COL_MAX)) ? COL_MAX
                                                     : col_sum[COLUMN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_adv) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_res_byte   <= n_res_byte;
            r_res_bvalid <= n_res_bvalid;
            r_res_done   <= r_s1_last;
            r_res_status <= n_ekind;
            r_res_line   <= n_res_line;
            r_res_col    <= n_res_col;
        end
    end

    assign o_out.valid        = r_res_valid;
    assign o_out.out_byte     = r_res_byte;
    assign o_out.out_valid    = r_res_bvalid;
    assign o_out.done_res     = r_res_done;
    assign o_out.status       = r_res_status;
    assign o_out.error_line   = r_res_line;
    assign o_out.error_column = r_res_col;

    // a finished scalar leaves the scanner waiting for a quote
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_last |=> r_mode == MODE_OPEN)
        else $error("scan mode not reset after last byte");

    // skipping only happens with an error recorded
    a_skip_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_SKIP |-> r_ekind != ST_OK)
        else $error("skip mode without error kind");

    // no decoded byte means a zero byte
    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !r_res_bvalid |-> r_res_byte == 8'h00)
        else $error("nonzero byte with out_valid low");

    // no error means no position
    a_ok_no_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_status == ST_OK |-> r_res_line == '0 && r_res_col == '0)
        else $error("error position set without error");

endmodule

`default_nettype wire
